@@ src/epd_pkg.sv @@
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants of the packet deframer: framing codes, row
// codes, configuration register indexes and the record passed from the
// byte parser to the result stage.
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] EXT_CODE_MIN    = 8'h80;

    localparam logic [7:0] MIN_LEN_RESET   = 8'd20;
    localparam logic [7:0] ATT_THR_RESET   = 8'd60;

    localparam logic [0:0] CFG_IDX_MIN_LEN = 1'b0;
    localparam logic [0:0] CFG_IDX_ATT_THR = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } frame_phase_t;

    typedef enum logic [1:0] {
        RP_CODE,
        RP_VALUE,
        RP_XLEN,
        RP_XDATA
    } row_phase_t;

    typedef struct packed {
        logic       length_err;
        logic       sum_ok;
        logic [7:0] declared_length;
        logic       att_seen;
        logic [7:0] att_value;
        logic       med_seen;
        logic [7:0] med_value;
    } pkt_record_t;

endpackage

@@ src/epd_front.sv @@
// ----------------------------------------------------------------------------
// epd_front
// Byte parser: sync hunt, length check, payload sum and row decoding.
// Emits one record per finished packet or rejected length byte.
// ----------------------------------------------------------------------------
module epd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_fire,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output epd_pkg::pkt_record_t push_data
);

    epd_pkg::frame_phase_t phase_reg, phase_next;
    epd_pkg::row_phase_t   row_phase_reg, row_phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] decl_len_reg, decl_len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] row_code_reg, row_code_next;
    logic [7:0] row_left_reg, row_left_next;
    logic [8:0] att_reg, att_next;
    logic [8:0] med_reg, med_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= epd_pkg::PH_SYNC1;
            row_phase_reg  <= epd_pkg::RP_CODE;
            bytes_left_reg <= '0;
            decl_len_reg   <= '0;
            sum_reg        <= '0;
            row_code_reg   <= '0;
            row_left_reg   <= '0;
            att_reg        <= '0;
            med_reg        <= '0;
        end else begin
            phase_reg      <= phase_next;
            row_phase_reg  <= row_phase_next;
            bytes_left_reg <= bytes_left_next;
            decl_len_reg   <= decl_len_next;
            sum_reg        <= sum_next;
            row_code_reg   <= row_code_next;
            row_left_reg   <= row_left_next;
            att_reg        <= att_next;
            med_reg        <= med_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        row_phase_next  = row_phase_reg;
        bytes_left_next = bytes_left_reg;
        decl_len_next   = decl_len_reg;
        sum_next        = sum_reg;
        row_code_next   = row_code_reg;
        row_left_next   = row_left_reg;
        att_next        = att_reg;
        med_next        = med_reg;
        push            = 1'b0;
        push_data       = '0;
        if (byte_fire) begin
            case (phase_reg)
                epd_pkg::PH_SYNC1: begin
                    if (rx_byte == epd_pkg::SYNC_BYTE) begin
                        phase_next = epd_pkg::PH_SYNC2;
                    end
                end
                epd_pkg::PH_SYNC2: begin
                    phase_next = (rx_byte == epd_pkg::SYNC_BYTE) ? epd_pkg::PH_LEN
                                                                 : epd_pkg::PH_SYNC1;
                end
                epd_pkg::PH_LEN: begin
                    if (rx_byte > epd_pkg::SYNC_BYTE) begin
                        phase_next           = epd_pkg::PH_SYNC1;
                        push                 = 1'b1;
                        push_data.length_err = 1'b1;
                    end else if (rx_byte != epd_pkg::SYNC_BYTE) begin
                        decl_len_next   = rx_byte;
                        bytes_left_next = rx_byte;
                        sum_next        = '0;
                        row_phase_next  = epd_pkg::RP_CODE;
                        row_code_next   = '0;
                        row_left_next   = '0;
                        att_next        = '0;
                        med_next        = '0;
                        phase_next      = (rx_byte == 8'd0) ? epd_pkg::PH_CHECK
                                                            : epd_pkg::PH_PAYLOAD;
                    end
                end
                epd_pkg::PH_PAYLOAD: begin
                    sum_next        = sum_reg + rx_byte;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1) begin
                        phase_next = epd_pkg::PH_CHECK;
                    end
                    case (row_phase_reg)
                        epd_pkg::RP_CODE: begin
                            row_code_next  = rx_byte;
                            row_phase_next = (rx_byte < epd_pkg::EXT_CODE_MIN)
                                             ? epd_pkg::RP_VALUE : epd_pkg::RP_XLEN;
                        end
                        epd_pkg::RP_VALUE: begin
                            if (row_code_reg == epd_pkg::CODE_ATTENTION) begin
                                att_next = {1'b1, rx_byte};
                            end
                            if (row_code_reg == epd_pkg::CODE_MEDITATION) begin
                                med_next = {1'b1, rx_byte};
                            end
                            row_phase_next = epd_pkg::RP_CODE;
                        end
                        epd_pkg::RP_XLEN: begin
                            row_left_next  = rx_byte;
                            row_phase_next = (rx_byte == 8'd0) ? epd_pkg::RP_CODE
                                                               : epd_pkg::RP_XDATA;
                        end
                        default: begin
                            row_left_next = row_left_reg - 8'd1;
                            if (row_left_reg == 8'd1) begin
                                row_phase_next = epd_pkg::RP_CODE;
                            end
                        end
                    endcase
                end
                default: begin
                    phase_next                = epd_pkg::PH_SYNC1;
                    push                      = 1'b1;
                    push_data.sum_ok          = (rx_byte == ~sum_reg);
                    push_data.declared_length = decl_len_reg;
                    push_data.att_seen        = att_reg[8];
                    push_data.att_value       = att_reg[7:0];
                    push_data.med_seen        = med_reg[8];
                    push_data.med_value       = med_reg[7:0];
                end
            endcase
        end
    end

endmodule

@@ src/epd_queue.sv @@
// ----------------------------------------------------------------------------
// epd_queue
// Small FIFO of packet records between the byte parser and the result stage.
// ----------------------------------------------------------------------------
module epd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  epd_pkg::pkt_record_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output epd_pkg::pkt_record_t head
);

    epd_pkg::pkt_record_t mem [epd_pkg::QUEUE_DEPTH];

    logic [epd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [epd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [epd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full    = (count_reg == epd_pkg::QCNT_W'(epd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/epd_back.sv @@
// ----------------------------------------------------------------------------
// epd_back
// Result stage: holds the configuration registers, turns a packet record
// into a status and value report and holds it in the output register.
// ----------------------------------------------------------------------------
module epd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_fire,
    input  logic [0:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 q_empty,
    input  epd_pkg::pkt_record_t q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    logic [7:0]  min_len_reg;
    logic [7:0]  att_thr_reg;
    logic        valid_reg;
    logic [31:0] data_reg, data_next;
    logic [1:0]  status_reg, status_next;
    logic        vv;
    logic        aseen;
    logic        mseen;
    logic [7:0]  aval;
    logic [7:0]  mval;
    logic        ahigh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= epd_pkg::MIN_LEN_RESET;
            att_thr_reg <= epd_pkg::ATT_THR_RESET;
        end else if (cfg_fire) begin
            case (cfg_index)
                epd_pkg::CFG_IDX_MIN_LEN: min_len_reg <= cfg_data;
                epd_pkg::CFG_IDX_ATT_THR: att_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        vv    = !q_head.length_err && q_head.sum_ok
                && (q_head.declared_length > min_len_reg);
        aseen = vv && q_head.att_seen;
        mseen = vv && q_head.med_seen;
        aval  = aseen ? q_head.att_value : 8'd0;
        mval  = mseen ? q_head.med_value : 8'd0;
        ahigh = aseen && (aval > att_thr_reg);
        if (q_head.length_err) begin
            status_next = epd_pkg::STATUS_LEN_ERR;
            data_next   = '0;
        end else begin
            status_next = q_head.sum_ok ? epd_pkg::STATUS_OK : epd_pkg::STATUS_CSUM_ERR;
            data_next   = {4'd0, ahigh, mval, mseen, aval, aseen, vv,
                           q_head.declared_length};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;

endmodule

@@ src/eeg_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// eeg_packet_deframer_unit
// Deframes a serial stream of biosignal packets and reports one status per
// packet, with attention and meditation values for long accepted packets.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while s_tready is high. The byte parser
// handles every byte in the cycle it is transferred and, at a checksum byte or a
// bad length byte, writes a packet record into a four-entry queue; the result
// stage drains the queue into the output register, one report per cycle while
// that register is free or being read. s_tready drops only when that queue is
// full, i.e. after four reports have piled up behind a stalled report in the
// output register. A report goes through the queue and then the output register.
// Configuration writes are taken every cycle and are meant for an idle block.
module eeg_packet_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] payload_length, [8] values_valid,
                                     // [9] attention_seen, [17:10] attention_value,
                                     // [18] meditation_seen, [26:19] meditation_value,
                                     // [27] attention_high, [31:28] zero
    output logic [1:0]  m_tuser,     // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    epd_pkg::pkt_record_t push_data;
    epd_pkg::pkt_record_t q_head;
    logic push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic byte_fire;

    assign s_tready  = !q_full;
    assign byte_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    epd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .push      (push),
        .push_data (push_data)
    );

    epd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    epd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ src/epd_checker.sv @@
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks on the deframer's report stream, bound to the top level.
// ----------------------------------------------------------------------------
module epd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled report changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("report valid after reset");

    a_len_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == epd_pkg::STATUS_LEN_ERR |-> m_tdata == 32'd0)
        else $error("length error report carries data");

    a_values_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[31:9] == 23'd0)
        else $error("values reported without values_valid");

    a_status_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tuser == epd_pkg::STATUS_OK)
        else $error("values_valid on a rejected packet");

endmodule

bind eeg_packet_deframer_unit epd_checker u_epd_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for eeg_packet_deframer_unit. A driver streams received
// bytes from a queue, a monitor predicts the packet reports from every accepted
// byte and checks each report field by field, and both stream sides stall at
// random. The run covers directed framing corner cases, then random packets
// (mostly well formed, some corrupt or broken) under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import epd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] payload_length;
        logic       values_valid;
        logic       att_seen;
        logic [7:0] att_value;
        logic       med_seen;
        logic [7:0] med_value;
        logic       att_high;
    } report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_IDX_MIN_LEN;
    logic [7:0]  cfg_data  = 8'h00;

    logic [7:0]   rx_pending[$];
    report_t      awaited_reports[$];
    int           bytes_queued = 0;
    int           error_count  = 0;
    int           cycle_count  = 0;
    bit           steady       = 1'b0;

    // deframer state as seen by the predictor
    logic [7:0]   cfg_min_length    = MIN_LEN_RESET;
    logic [7:0]   cfg_att_threshold = ATT_THR_RESET;
    frame_phase_t fr_phase          = PH_SYNC1;
    row_phase_t   row_state         = RP_CODE;
    logic [7:0]   bytes_remaining   = 8'h00;
    logic [7:0]   pkt_length        = 8'h00;
    logic [7:0]   pkt_sum           = 8'h00;
    logic [7:0]   cur_code          = 8'h00;
    logic [7:0]   skip_count        = 8'h00;
    logic [8:0]   att_reg           = 9'h000;
    logic [8:0]   med_reg           = 9'h000;

    eeg_packet_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic note_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        report_t rep;
        logic    ok;
        rep = '0;
        case (fr_phase)
            PH_SYNC1: begin
                if (b == SYNC_BYTE) fr_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                fr_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            end
            PH_LEN: begin
                if (b > SYNC_BYTE) begin
                    fr_phase = PH_SYNC1;
                    rep.status = STATUS_LEN_ERR;
                    awaited_reports.push_back(rep);
                end else if (b != SYNC_BYTE) begin
                    pkt_length      = b;
                    bytes_remaining = b;
                    pkt_sum         = 8'h00;
                    row_state       = RP_CODE;
                    cur_code        = 8'h00;
                    skip_count      = 8'h00;
                    att_reg         = 9'h000;
                    med_reg         = 9'h000;
                    fr_phase = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pkt_sum = pkt_sum + b;
                case (row_state)
                    RP_CODE: begin
                        cur_code  = b;
                        row_state = (b < EXT_CODE_MIN) ? RP_VALUE : RP_XLEN;
                    end
                    RP_VALUE: begin
                        if (cur_code == CODE_ATTENTION) att_reg = {1'b1, b};
                        if (cur_code == CODE_MEDITATION) med_reg = {1'b1, b};
                        row_state = RP_CODE;
                    end
                    RP_XLEN: begin
                        skip_count = b;
                        row_state  = (b == 8'h00) ? RP_CODE : RP_XDATA;
                    end
                    default: begin
                        skip_count = skip_count - 8'd1;
                        if (skip_count == 8'h00) row_state = RP_CODE;
                    end
                endcase
                bytes_remaining = bytes_remaining - 8'd1;
                if (bytes_remaining == 8'h00) fr_phase = PH_CHECK;
            end
            default: begin
                ok = (b == ~pkt_sum);
                rep.status         = ok ? STATUS_OK : STATUS_CSUM_ERR;
                rep.payload_length = pkt_length;
                rep.values_valid   = ok && (pkt_length > cfg_min_length);
                if (rep.values_valid) begin
                    rep.att_seen  = att_reg[8];
                    rep.att_value = att_reg[8] ? att_reg[7:0] : 8'h00;
                    rep.med_seen  = med_reg[8];
                    rep.med_value = med_reg[8] ? med_reg[7:0] : 8'h00;
                    rep.att_high  = att_reg[8] && (att_reg[7:0] > cfg_att_threshold);
                end
                fr_phase = PH_SYNC1;
                awaited_reports.push_back(rep);
            end
        endcase
    endtask

    // driver: advance only on a transfer or while idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
                s_tdata  <= rx_pending.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin : monitor
        report_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    note_error($sformatf("unexpected report, status %0d length %0d",
                                         m_tuser, m_tdata[7:0]));
                end else begin
                    want = awaited_reports.pop_front();
                    if (m_tuser != want.status)
                        note_error($sformatf("status got %0d want %0d",
                                             m_tuser, want.status));
                    if (m_tdata[7:0] != want.payload_length)
                        note_error($sformatf("payload_length got %0d want %0d",
                                             m_tdata[7:0], want.payload_length));
                    if (m_tdata[8] != want.values_valid)
                        note_error($sformatf("values_valid got %0d want %0d",
                                             m_tdata[8], want.values_valid));
                    if (m_tdata[9] != want.att_seen)
                        note_error($sformatf("attention_seen got %0d want %0d",
                                             m_tdata[9], want.att_seen));
                    if (m_tdata[17:10] != want.att_value)
                        note_error($sformatf("attention_value got %0d want %0d",
                                             m_tdata[17:10], want.att_value));
                    if (m_tdata[18] != want.med_seen)
                        note_error($sformatf("meditation_seen got %0d want %0d",
                                             m_tdata[18], want.med_seen));
                    if (m_tdata[26:19] != want.med_value)
                        note_error($sformatf("meditation_value got %0d want %0d",
                                             m_tdata[26:19], want.med_value));
                    if (m_tdata[27] != want.att_high)
                        note_error($sformatf("attention_high got %0d want %0d",
                                             m_tdata[27], want.att_high));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_register(input logic [0:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_MIN_LEN) cfg_min_length = val;
        else cfg_att_threshold = val;
    endtask

    task automatic drain();
        while (rx_pending.size() != 0 || s_tvalid || awaited_reports.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_packet(input logic [7:0] payload[$], input bit corrupt,
                                input bit extra_sync);
        logic [7:0] sum;
        sum = 8'h00;
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        if (extra_sync) queue_byte(SYNC_BYTE);
        queue_byte(8'(payload.size()));
        foreach (payload[i]) begin
            queue_byte(payload[i]);
            sum = sum + payload[i];
        end
        queue_byte(corrupt ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_random_packet();
        logic [7:0] payload[$];
        int         kind;
        int         len;
        int         xlen;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
            return;
        end
        if (kind < 10) begin
            queue_byte(SYNC_BYTE);
            queue_byte(8'($urandom_range(0, 169)));
            return;
        end
        if (kind < 15) begin
            queue_byte(SYNC_BYTE);
            queue_byte(SYNC_BYTE);
            repeat ($urandom_range(0, 2)) queue_byte(SYNC_BYTE);
            queue_byte(8'($urandom_range(171, 255)));
            return;
        end
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 169) : $urandom_range(0, 30);
        while (payload.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    payload.push_back(CODE_ATTENTION);
                    payload.push_back(pick_value());
                end
                3, 4: begin
                    payload.push_back(CODE_MEDITATION);
                    payload.push_back(pick_value());
                end
                5, 6: begin
                    payload.push_back(8'($urandom_range(0, 127)));
                    payload.push_back(8'($urandom));
                end
                7, 8: begin
                    xlen = $urandom_range(0, 5);
                    payload.push_back(8'($urandom_range(128, 255)));
                    payload.push_back(8'(xlen));
                    repeat (xlen) payload.push_back(8'($urandom));
                end
                default: payload.push_back(8'($urandom));
            endcase
        end
        while (payload.size() > len) void'(payload.pop_back());
        queue_packet(payload, kind < 22, $urandom_range(0, 9) == 0);
    endtask

    task automatic run_phase(input logic [7:0] min_len, input logic [7:0] threshold,
                             input int n_bytes);
        int start;
        write_register(CFG_IDX_MIN_LEN, min_len);
        write_register(CFG_IDX_ATT_THR, threshold);
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) queue_random_packet();
        drain();
    endtask

    initial begin : stimulus
        logic [7:0] body[$];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_register(CFG_IDX_MIN_LEN, 8'd2);
        write_register(CFG_IDX_ATT_THR, 8'h7F);

        // noise, broken sync, skipped sync in the length slot, length error
        queue_byte(8'h00);
        queue_byte(SYNC_BYTE);
        queue_byte(8'h55);
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        queue_byte(8'hAB);
        // zero-length packets, good and bad checksum
        body.delete();
        queue_packet(body, 1'b0, 1'b0);
        queue_packet(body, 1'b1, 1'b0);
        // repeated attention, a skipped extended row, row cut short at the end
        body = '{CODE_ATTENTION, 8'h10, 8'h80, 8'h01, 8'h5A,
                 CODE_ATTENTION, 8'hC8, CODE_MEDITATION, 8'h37, 8'h07};
        queue_packet(body, 1'b0, 1'b0);
        drain();

        run_phase(8'd20, 8'd60, 105);
        run_phase(8'd0, 8'd0, 105);
        steady = 1'b1;
        run_phase(8'd169, 8'd255, 105);
        steady = 1'b0;
        run_phase(8'($urandom_range(0, 40)), 8'($urandom), 105);
        run_phase(8'd5, 8'($urandom_range(100, 200)), 105);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ eeg_packet_deframer_unit.f @@
src/epd_pkg.sv
src/epd_front.sv
src/epd_queue.sv
src/epd_back.sv
src/eeg_packet_deframer_unit.sv
src/epd_checker.sv
tb/sv/testbench.sv
